### rtl/assert_macros.svh
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising clock edge outside reset
`define NFLA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define NFLA_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NFLA_ASSERT(lbl, clk, rst, prop, msg)
`define NFLA_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/nfla_pkg.sv
// Constants and types of the number free list allocator
package nfla_pkg;

   localparam int MAX_NUMBERS = 1024;
   localparam int NUM_W       = $clog2(MAX_NUMBERS);
   localparam int SIZE_W      = NUM_W + 1;
   localparam int KIND_W      = 2;

   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_NUMBERS);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_NUMBERS);
   localparam logic [NUM_W-1:0]  NUM_LAST   = NUM_W'(MAX_NUMBERS - 1);

   // Operation codes of a request word
   localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

endpackage

### rtl/number_free_list_allocator_unit.sv
// Number allocator: LIFO free list of released numbers over a fresh-number count
// The response word is registered when the accepted request commits from the execute state.
// A new request is stalled until the current one commits; the in-use map and release stack
// each take a registered synchronous read followed by a write-back when the request commits.
// Reset and every size write clear the in-use map one entry a cycle, with req_stall high;
// the stack needs no clearing since its depth restarts at zero.
`include "assert_macros.svh"

module number_free_list_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nfla_pkg::KIND_W-1:0]   req_kind,
   input  logic [nfla_pkg::NUM_W-1:0]    req_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nfla_pkg::NUM_W-1:0]    rsp_given_number,
   output logic                          rsp_success,
   output logic                          rsp_is_free,
   output logic                          rsp_out_of_range,
   input  logic                          csr_we,
   input  logic [nfla_pkg::SIZE_W-1:0]   csr_wdata
);
   import nfla_pkg::*;

   // Memories
   logic             map_mem   [MAX_NUMBERS];
   logic [NUM_W-1:0] stack_mem [MAX_NUMBERS];

   // Control state
   state_type         state_ff, state_in;
   logic [NUM_W-1:0]  clr_ff, clr_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] fresh_ff, fresh_in;
   logic [SIZE_W-1:0] depth_ff, depth_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Request and response payload
   logic [KIND_W-1:0] kind_ff;
   logic [NUM_W-1:0]  number_ff;
   logic [NUM_W-1:0]  given_ff;
   logic              success_ff, is_free_ff, oor_ff;

   // Memory ports
   logic              map_rdata_ff;
   logic [NUM_W-1:0]  stack_rdata_ff;
   logic              map_we;
   logic [NUM_W-1:0]  map_waddr, map_raddr;
   logic              map_wdata;
   logic              stack_we;
   logic [NUM_W-1:0]  stack_raddr;

   // Execute-stage signals
   logic              req_accept, commit;
   logic              num_oor, have_stack, have_fresh;
   logic [SIZE_W-1:0] depth_m1, fresh_m1, size_sat;
   logic [NUM_W-1:0]  give_num;
   logic [NUM_W-1:0]  res_given;
   logic              res_success, res_is_free, res_oor;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign depth_m1   = depth_ff - SIZE_W'(1);
   assign fresh_m1   = fresh_ff - SIZE_W'(1);
   assign have_stack = (depth_ff != '0);
   assign have_fresh = (fresh_ff != '0);
   assign give_num   = have_stack ? stack_rdata_ff : fresh_m1[NUM_W-1:0];
   assign num_oor    = ({1'b0, number_ff} >= size_ff);
   assign size_sat   = (csr_wdata > SIZE_MAX) ? SIZE_MAX : csr_wdata;

   // Read the map at the incoming number, then hold the address while executing
   assign map_raddr   = (state_ff == ST_IDLE) ? req_number : number_ff;
   assign stack_raddr = depth_m1[NUM_W-1:0];

   // Decode the operation and build the response and write-back
   always_comb begin
      res_given   = '0;
      res_success = 1'b0;
      res_is_free = 1'b0;
      res_oor     = 1'b0;
      map_we      = 1'b0;
      map_waddr   = clr_ff;
      map_wdata   = 1'b0;
      stack_we    = 1'b0;
      fresh_in    = fresh_ff;
      depth_in    = depth_ff;
      if (state_ff == ST_CLEAR) begin
         map_we = 1'b1;
      end
      unique case (kind_ff)
         KIND_GET: begin
            if (have_stack || have_fresh) begin
               res_given   = give_num;
               res_success = 1'b1;
               if (commit) begin
                  map_we    = 1'b1;
                  map_waddr = give_num;
                  map_wdata = 1'b1;
                  if (have_stack) begin
                     depth_in = depth_m1;
                  end else begin
                     fresh_in = fresh_m1;
                  end
               end
            end
         end
         KIND_CHECK: begin
            res_oor     = num_oor;
            res_is_free = !num_oor && !map_rdata_ff;
         end
         KIND_RELEASE: begin
            res_oor = num_oor;
            if (!num_oor && map_rdata_ff) begin
               res_success = 1'b1;
               if (commit) begin
                  map_we    = 1'b1;
                  map_waddr = number_ff;
                  if (depth_ff < SIZE_W'(MAX_NUMBERS)) begin
                     stack_we = 1'b1;
                     depth_in = depth_ff + SIZE_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      // A size write restarts the allocator
      if (csr_we) begin
         fresh_in = size_sat;
         depth_in = '0;
      end
   end

   // Sequence clearing, idle and execute
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + NUM_W'(1);
            if (clr_ff == NUM_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_we) begin
         size_in  = size_sat;
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   // Advance control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= SIZE_RESET;
         fresh_ff     <= SIZE_RESET;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_ff      <= size_in;
         fresh_ff     <= fresh_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request and load the response word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff   <= req_kind;
         number_ff <= req_number;
      end
      if (commit) begin
         given_ff   <= res_given;
         success_ff <= res_success;
         is_free_ff <= res_is_free;
         oor_ff     <= res_oor;
      end
   end

   // In-use map: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
   end

   // Release stack: push at the depth, read the top
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[depth_ff[NUM_W-1:0]] <= number_ff;
      end
      stack_rdata_ff <= stack_mem[stack_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_given_number = given_ff;
   assign rsp_success      = success_ff;
   assign rsp_is_free      = is_free_ff;
   assign rsp_out_of_range = oor_ff;

   // Free numbers never exceed the managed size
   `NFLA_ASSERT(a_free_bound, clock, reset, ({1'b0, depth_ff} + {1'b0, fresh_ff}) <= {1'b0, size_ff}, "free list larger than size")
   // A committed operation shows up as a response word
   `NFLA_ASSERT(a_commit_rsp, clock, reset, commit |=> rsp_valid_ff, "committed word not presented")
   // Out of range excludes success and free
   `NFLA_NEVER(a_oor_excl, clock, reset, rsp_valid_ff && oor_ff && (success_ff || is_free_ff), "out of range word also reports success or free")

endmodule

### sim/tb_number_free_list_allocator_unit.sv
// Self-checking testbench of the number free list allocator unit
module tb_number_free_list_allocator_unit;
   import nfla_pkg::*;

   // Kind code that names no operation
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int QUIET_LIMIT    = 5000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int PHASES         = 7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NUM_W-1:0]  number;
   } request_word_type;

   typedef struct packed {
      logic [NUM_W-1:0] given_number;
      logic             success;
      logic             is_free;
      logic             out_of_range;
   } result_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [NUM_W-1:0]  req_number = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [NUM_W-1:0]  rsp_given_number;
   logic              rsp_success;
   logic              rsp_is_free;
   logic              rsp_out_of_range;
   logic              csr_we = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   // Allocator copy used for prediction
   int                alloc_size;
   int                fresh_left;
   int                returned_depth;
   logic [NUM_W-1:0]  returned_stack [MAX_NUMBERS];
   bit [MAX_NUMBERS-1:0] busy_map;

   request_word_type  pending_words[$];
   result_word_type   expected_results[$];
   logic              req_taken = 1'b0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   bit                pressure_on = 1'b0;
   int                holdoff_done = 0;
   int                quiet_cycles = 0;
   int                words_queued = 0;
   int                words_accepted = 0;
   int                errors = 0;
   int                settings_written = 0;
   int                grants = 0;
   int                refusals = 0;
   int                returns_ok = 0;
   int                range_hits = 0;

   int phase_size  [PHASES] = '{8, 3, 16, 64, 1024, 5, 2};
   int phase_send  [PHASES] = '{0, 84, 0, 23, 0, 0, 23};
   int phase_stall [PHASES] = '{0, 0, 84, 23, 0, 0, 23};
   int phase_count [PHASES] = '{110, 90, 100, 110, 110, 90, 90};

   number_free_list_allocator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_number       (req_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_given_number (rsp_given_number),
      .rsp_success      (rsp_success),
      .rsp_is_free      (rsp_is_free),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Restart the allocator copy: saturate the size, empty the list, clear the map
   function automatic void restart_allocator(input logic [SIZE_W-1:0] value);
      alloc_size     = (value > MAX_NUMBERS) ? MAX_NUMBERS : int'(value);
      fresh_left     = alloc_size;
      returned_depth = 0;
      busy_map       = '0;
   endfunction

   // Apply one request word to the allocator copy and return its response word
   function automatic result_word_type allocate_step(input request_word_type w);
      result_word_type r;
      r = '0;
      case (w.kind)
         KIND_GET: begin
            if (returned_depth > 0) begin
               returned_depth--;
               r.given_number = returned_stack[returned_depth];
               r.success      = 1'b1;
            end else if (fresh_left > 0) begin
               fresh_left--;
               r.given_number = NUM_W'(fresh_left);
               r.success      = 1'b1;
            end
            if (r.success) begin
               busy_map[r.given_number] = 1'b1;
               grants++;
            end else begin
               refusals++;
            end
         end
         KIND_CHECK: begin
            if (w.number >= alloc_size) begin
               r.out_of_range = 1'b1;
               range_hits++;
            end else begin
               r.is_free = !busy_map[w.number];
            end
         end
         KIND_RELEASE: begin
            if (w.number >= alloc_size) begin
               r.out_of_range = 1'b1;
               range_hits++;
            end else if (busy_map[w.number]) begin
               busy_map[w.number] = 1'b0;
               r.success = 1'b1;
               returns_ok++;
               if (returned_depth < MAX_NUMBERS) begin
                  returned_stack[returned_depth] = w.number;
                  returned_depth++;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] number);
      request_word_type w;
      w.kind        = kind;
      w.number      = number;
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   // Queue random words; check and release numbers mostly fall near those handed out
   task automatic queue_random(input int count);
      int roll;
      int issued;
      int lo;
      int hi;
      logic [KIND_W-1:0] kind;
      logic [NUM_W-1:0] number;
      issued = 0;
      for (int i = 0; i < count; i++) begin
         roll   = $urandom_range(99);
         number = NUM_W'($urandom);
         if (roll < 45) begin
            kind = KIND_GET;
            issued++;
         end else if (roll < 95) begin
            kind = (roll < 65) ? KIND_CHECK : KIND_RELEASE;
            lo   = (alloc_size - issued - 2 > 0) ? alloc_size - issued - 2 : 0;
            hi   = (alloc_size + 1 < MAX_NUMBERS) ? alloc_size + 1 : MAX_NUMBERS - 1;
            if ($urandom_range(9) != 0)
               number = NUM_W'($urandom_range(hi, lo));
         end else begin
            kind = KIND_NONE;
         end
         queue_word(kind, number);
      end
   endtask

   // Wait until every queued word is taken and every response has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (words_accepted != words_queued || expected_results.size() != 0);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      restart_allocator(value);
      settings_written++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Drive request words at the falling edge; hold a stalled word
   always @(negedge clock) begin : feed
      request_word_type word;
      logic             offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid && !req_taken;
         if (!offer && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            word       = pending_words.pop_front();
            req_kind   <= word.kind;
            req_number <= word.number;
            offer      = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // Stall the response side at random, or hold off for a long stretch once
   always @(negedge clock) begin : drain
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (pressure_on && holdoff_done < HOLDOFF_CYCLES) begin
         rsp_stall    <= 1'b1;
         holdoff_done <= holdoff_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Predict each accepted request word, then check each accepted response word
   always @(posedge clock) begin : observe
      result_word_type want;
      result_word_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            want             = allocate_step('{req_kind, req_number});
            expected_results = {expected_results, want};
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_given_number, rsp_success, rsp_is_free, rsp_out_of_range};
            if (expected_results.size() == 0) begin
               $display("%0t: response word with none expected, actual %p", $time, got);
               errors++;
            end else begin
               want = expected_results.pop_front();
               compare_field("given_number", want.given_number, got.given_number);
               compare_field("success", want.success, got.success);
               compare_field("is_free", want.is_free, got.is_free);
               compare_field("out_of_range", want.out_of_range, got.out_of_range);
            end
         end
      end
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("number_free_list_allocator_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      restart_allocator(SIZE_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full size after reset: fresh issue, LIFO reuse, double release, unused kind
      queue_word(KIND_GET, '0);
      queue_word(KIND_GET, NUM_LAST);
      queue_word(KIND_CHECK, NUM_LAST);
      queue_word(KIND_CHECK, '0);
      queue_word(KIND_RELEASE, NUM_LAST);
      queue_word(KIND_RELEASE, NUM_LAST);
      queue_word(KIND_NONE, NUM_LAST);
      queue_word(KIND_RELEASE, NUM_LAST - NUM_W'(1));
      queue_word(KIND_GET, '0);
      queue_word(KIND_GET, '0);
      queue_word(KIND_GET, NUM_LAST);

      // One number: empty list and out of range
      write_size(SIZE_W'(1));
      queue_word(KIND_GET, '0);
      queue_word(KIND_GET, '0);
      queue_word(KIND_CHECK, NUM_W'(1));
      queue_word(KIND_RELEASE, NUM_LAST);
      queue_word(KIND_CHECK, '0);
      queue_word(KIND_RELEASE, '0);
      queue_word(KIND_CHECK, '0);

      // No numbers at all
      write_size('0);
      queue_word(KIND_GET, '0);
      queue_word(KIND_CHECK, '0);
      queue_word(KIND_RELEASE, '0);

      // Size above the maximum saturates
      write_size('1);
      queue_word(KIND_GET, '0);
      queue_word(KIND_CHECK, NUM_LAST);
      queue_word(KIND_RELEASE, NUM_LAST);
      queue_word(KIND_CHECK, NUM_LAST);

      // Random phases at several sizes and idling patterns
      for (int p = 0; p < PHASES; p++) begin
         write_size(SIZE_W'(phase_size[p]));
         send_idle_pct = phase_send[p];
         stall_pct     = phase_stall[p];
         if (p == 5) begin
            do @(negedge clock);
            while (req_stall);
            pressure_on = 1'b1;
         end
         queue_random(phase_count[p]);
         wait_idle();
         pressure_on = 1'b0;
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      wait_idle();
      repeat (8) @(negedge clock);
      $display("Covered %0d request words over %0d size settings: %0d numbers issued,",
               words_accepted, settings_written, grants);
      $display("%0d gets refused, %0d numbers returned, %0d out-of-range requests",
               refusals, returns_ok, range_hits);
      if (errors == 0) begin
         $display("number_free_list_allocator_unit test passed");
      end else begin
         $display("number_free_list_allocator_unit test failed");
      end
      $finish;
   end

endmodule
